@@ rtl/assert_macros.svh @@
// assertion macros shared by the hash insert block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HTP_ASSERT_SAME(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("htp assertion failed");

// next-cycle implication
`define HTP_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("htp assertion failed");

`endif

@@ rtl/htp_pkg.sv @@
// shared constants and control types of the hash insert block
package htp_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int HANDLE_BITS_DEF = 16;

    localparam int CFG_W    = 11;
    localparam int DIGIT_W  = 4;
    localparam int HANDLE_W = 16;
    localparam int SLOT_W   = 10;
    localparam int PROBE_W  = 11;
    localparam int TOTAL_W  = 32;
    localparam int HASH_W   = 11;
    localparam int CNT_W    = 4;
    localparam int STEP_PAD = HASH_W - DIGIT_W;

    localparam int HUNDRED = 100;
    localparam int TEN     = 10;

    typedef struct packed {
        logic idle;
        logic clear_wr;
        logic accept;
        logic latch_home;
        logic latch_step;
        logic probe;
        logic finish;
    } htp_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic clear_last;
        logic rem_done;
        logic slot_busy;
        logic next_home;
        logic out_free;
    } htp_sts_t;

endpackage

@@ rtl/htp_in_if.sv @@
// insert request channel
interface htp_in_if;
    logic                         valid;
    logic                         ready;
    logic [htp_pkg::DIGIT_W-1:0]  step_digit;
    logic [htp_pkg::DIGIT_W-1:0]  hundreds_digit;
    logic [htp_pkg::DIGIT_W-1:0]  tens_digit;
    logic [htp_pkg::DIGIT_W-1:0]  units_digit;
    logic [htp_pkg::HANDLE_W-1:0] entry_handle;

    modport source (
        output valid, step_digit, hundreds_digit, tens_digit, units_digit, entry_handle,
        input  ready
    );

    modport sink (
        input  valid, step_digit, hundreds_digit, tens_digit, units_digit, entry_handle,
        output ready
    );
endinterface

@@ rtl/htp_out_if.sv @@
// insert result channel
interface htp_out_if;
    logic                         valid;
    logic                         ready;
    logic [htp_pkg::SLOT_W-1:0]   slot_index;
    logic [htp_pkg::PROBE_W-1:0]  probe_count;
    logic [htp_pkg::TOTAL_W-1:0]  total_collisions;
    logic                         evicted;
    logic [htp_pkg::HANDLE_W-1:0] evicted_handle;

    modport source (
        output valid, slot_index, probe_count, total_collisions, evicted, evicted_handle,
        input  ready
    );

    modport sink (
        input  valid, slot_index, probe_count, total_collisions, evicted, evicted_handle,
        output ready
    );
endinterface

@@ rtl/htp_ram.sv @@
// generic simple dual-port ram with registered read
module htp_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/htp_rem_unit.sv @@
// bit-serial remainder unit, one dividend bit per cycle
`include "assert_macros.svh"

module htp_rem_unit #(
    parameter int SIZE_W = 11
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [htp_pkg::HASH_W-1:0] dividend,
    input  logic [htp_pkg::CNT_W-1:0]  bits,
    input  logic [SIZE_W-1:0]          divisor,
    output logic                       done,
    output logic [SIZE_W-1:0]          rem
);

    logic                       active_reg;
    logic                       done_reg;
    logic [htp_pkg::CNT_W-1:0]  cnt_reg;
    logic [htp_pkg::HASH_W-1:0] shift_reg;
    logic [SIZE_W-1:0]          rem_reg;
    logic [SIZE_W:0]            trial;
    logic [SIZE_W-1:0]          rem_next;

    always_comb
    begin
        trial = {rem_reg, shift_reg[htp_pkg::HASH_W-1]};
        if (trial >= (SIZE_W+1)'(divisor))
        begin
            rem_next = SIZE_W'(trial - (SIZE_W+1)'(divisor));
        end
        else
        begin
            rem_next = SIZE_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
            done_reg   <= 1'b0;
            cnt_reg    <= bits;
        end
        else if (active_reg)
        begin
            cnt_reg <= cnt_reg - htp_pkg::CNT_W'(1);
            if (cnt_reg == htp_pkg::CNT_W'(1))
            begin
                active_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end
        else if (active_reg)
        begin
            shift_reg <= shift_reg << 1;
            rem_reg   <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    `HTP_ASSERT_SAME(a_rem_below_divisor, clk, rst_n, done_reg, rem_reg < divisor)

endmodule

@@ rtl/htp_ctrl.sv @@
// insert sequencer: clearing pass, hashing, probing and result hand-off
module htp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  htp_pkg::htp_sts_t sts,
    output htp_pkg::htp_cmd_t cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH  = 7'b0000100,
        S_STEP  = 7'b0001000,
        S_READ  = 7'b0010000,
        S_CHECK = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (sts.rem_done)
                begin
                    cmd.latch_home = 1'b1;
                    state_next     = S_STEP;
                end
            end
            S_STEP:
            begin
                if (sts.rem_done)
                begin
                    cmd.latch_step = 1'b1;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!sts.slot_busy)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.probe  = 1'b1;
                    state_next = sts.next_home ? S_DONE : S_READ;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/htp_datapath.sv @@
// slot table, remainder unit, probe arithmetic and result register
`include "assert_macros.svh"

module htp_datapath #(
    parameter int TABLE_DEPTH = htp_pkg::TABLE_DEPTH_DEF,
    parameter int HANDLE_BITS = htp_pkg::HANDLE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [htp_pkg::CFG_W-1:0] cfg_data,
    input  htp_pkg::htp_cmd_t         cmd,
    output htp_pkg::htp_sts_t         sts,
    htp_in_if.sink                    insert_ch,
    htp_out_if.source                 result_ch
);

    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = IW + 2;
    localparam int EW = SW + htp_pkg::CFG_W;
    localparam int RW = HANDLE_BITS + 1;

    // configuration and state
    logic [SW-1:0]               eff_size_reg;
    logic [SW-1:0]               eff_size_next;
    logic [IW-1:0]               clear_addr_reg;
    logic [htp_pkg::TOTAL_W-1:0] total_reg;
    logic                        out_valid_reg;

    // per-insert working registers
    logic [HANDLE_BITS-1:0]      handle_reg;
    logic [htp_pkg::DIGIT_W-1:0] step_reg;
    logic [IW-1:0]               home_reg;
    logic [IW-1:0]               idx_reg;
    logic [IW-1:0]               stepm_reg;
    logic [htp_pkg::PROBE_W-1:0] probes_reg;
    logic                        evicted_reg;
    logic [HANDLE_BITS-1:0]      old_reg;

    // result registers
    logic [htp_pkg::SLOT_W-1:0]   slot_index_reg;
    logic [htp_pkg::PROBE_W-1:0]  probe_count_reg;
    logic [htp_pkg::TOTAL_W-1:0]  total_out_reg;
    logic                         evicted_out_reg;
    logic [htp_pkg::HANDLE_W-1:0] evicted_handle_reg;

    logic [EW-1:0]                   cfg_wide;
    logic [htp_pkg::HASH_W-1:0]      hash;
    logic                            rem_start;
    logic [htp_pkg::HASH_W-1:0]      rem_dividend;
    logic [htp_pkg::CNT_W-1:0]       rem_bits;
    logic                            rem_done;
    logic [SW-1:0]                   rem_val;
    logic [IW:0]                     sum;
    logic [IW-1:0]                   next_idx;
    logic                            ram_we;
    logic [IW-1:0]                   ram_waddr;
    logic [RW-1:0]                   ram_wdata;
    logic [RW-1:0]                   ram_rdata;
    logic                            rd_busy;
    logic [HANDLE_BITS-1:0]          rd_handle;
    logic [HANDLE_BITS+htp_pkg::HANDLE_W-1:0] handle_in_wide;
    logic [htp_pkg::HANDLE_W+HANDLE_BITS-1:0] handle_out_wide;
    logic [IW+htp_pkg::SLOT_W-1:0]            slot_wide;

    // effective size: zero acts as one, oversize clamps to depth
    always_comb
    begin
        cfg_wide = EW'(cfg_data);
        if (cfg_wide == '0)
        begin
            eff_size_next = SW'(1);
        end
        else if (cfg_wide > EW'(TABLE_DEPTH))
        begin
            eff_size_next = SW'(TABLE_DEPTH);
        end
        else
        begin
            eff_size_next = SW'(cfg_data);
        end
    end

    assign hash = htp_pkg::HASH_W'(insert_ch.hundreds_digit) * htp_pkg::HASH_W'(htp_pkg::HUNDRED)
                + htp_pkg::HASH_W'(insert_ch.tens_digit) * htp_pkg::HASH_W'(htp_pkg::TEN)
                + htp_pkg::HASH_W'(insert_ch.units_digit);

    assign rem_start    = cmd.accept | cmd.latch_home;
    assign rem_dividend = cmd.accept ? hash : {step_reg, {htp_pkg::STEP_PAD{1'b0}}};
    assign rem_bits     = cmd.accept ? htp_pkg::CNT_W'(htp_pkg::HASH_W)
                                     : htp_pkg::CNT_W'(htp_pkg::DIGIT_W);

    htp_rem_unit #(
        .SIZE_W (SW)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (rem_dividend),
        .bits     (rem_bits),
        .divisor  (eff_size_reg),
        .done     (rem_done),
        .rem      (rem_val)
    );

    // next probe slot, one conditional subtract
    always_comb
    begin
        sum = (IW+1)'(idx_reg) + (IW+1)'(stepm_reg);
        if (CW'(sum) >= CW'(eff_size_reg))
        begin
            next_idx = IW'(sum - (IW+1)'(eff_size_reg));
        end
        else
        begin
            next_idx = IW'(sum);
        end
    end

    assign ram_we    = cmd.clear_wr | cmd.finish;
    assign ram_waddr = cmd.clear_wr ? clear_addr_reg : idx_reg;
    assign ram_wdata = cmd.clear_wr ? '0 : {1'b1, handle_reg};

    htp_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_busy   = ram_rdata[HANDLE_BITS];
    assign rd_handle = ram_rdata[HANDLE_BITS-1:0];

    assign handle_in_wide  = {{HANDLE_BITS{1'b0}}, insert_ch.entry_handle};
    assign handle_out_wide = {{htp_pkg::HANDLE_W{1'b0}}, old_reg};
    assign slot_wide       = {{htp_pkg::SLOT_W{1'b0}}, idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_size_reg   <= SW'(TABLE_DEPTH);
            clear_addr_reg <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                eff_size_reg <= eff_size_next;
            end
            if (cmd.clear_wr)
            begin
                clear_addr_reg <= clear_addr_reg + IW'(1);
            end
            if (cmd.probe && (total_reg != '1))
            begin
                total_reg <= total_reg + htp_pkg::TOTAL_W'(1);
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            handle_reg  <= handle_in_wide[HANDLE_BITS-1:0];
            step_reg    <= insert_ch.step_digit;
            probes_reg  <= '0;
            evicted_reg <= 1'b0;
        end
        if (cmd.latch_home)
        begin
            home_reg <= IW'(rem_val);
            idx_reg  <= IW'(rem_val);
        end
        if (cmd.latch_step)
        begin
            stepm_reg <= IW'(rem_val);
        end
        if (cmd.probe)
        begin
            idx_reg    <= next_idx;
            probes_reg <= probes_reg + htp_pkg::PROBE_W'(1);
            if (idx_reg == home_reg)
            begin
                old_reg <= rd_handle;
            end
            if (next_idx == home_reg)
            begin
                evicted_reg <= 1'b1;
            end
        end
        if (cmd.finish)
        begin
            slot_index_reg     <= slot_wide[htp_pkg::SLOT_W-1:0];
            probe_count_reg    <= probes_reg;
            total_out_reg      <= total_reg;
            evicted_out_reg    <= evicted_reg;
            evicted_handle_reg <= evicted_reg ? handle_out_wide[htp_pkg::HANDLE_W-1:0] : '0;
        end
    end

    assign insert_ch.ready = cmd.idle;

    assign result_ch.valid            = out_valid_reg;
    assign result_ch.slot_index       = slot_index_reg;
    assign result_ch.probe_count      = probe_count_reg;
    assign result_ch.total_collisions = total_out_reg;
    assign result_ch.evicted          = evicted_out_reg;
    assign result_ch.evicted_handle   = evicted_handle_reg;

    assign sts.in_valid   = insert_ch.valid;
    assign sts.clear_last = (clear_addr_reg == IW'(TABLE_DEPTH - 1));
    assign sts.rem_done   = rem_done;
    assign sts.slot_busy  = rd_busy;
    assign sts.next_home  = (next_idx == home_reg);
    assign sts.out_free   = !out_valid_reg || result_ch.ready;

    `HTP_ASSERT_SAME(a_probe_in_range, clk, rst_n, cmd.probe, CW'(idx_reg) < CW'(eff_size_reg))
    `HTP_ASSERT_NEXT(a_return_evicts, clk, rst_n, cmd.probe && (next_idx == home_reg), evicted_reg)
    `HTP_ASSERT_SAME(a_finish_has_room, clk, rst_n, cmd.finish, !out_valid_reg || result_ch.ready)

endmodule

@@ rtl/hash_table_insert_digit_probe.sv @@
// top level of the open-addressing hash insert block
//
// insert_ch takes one word per insert: a step digit, three key digits and an entry handle.
// result_ch returns one word per insert: final slot, probe count, running
// collision total, eviction flag and evicted handle.
// cfg_we/cfg_data write the table size; write only while no insert is open.
// from accept to result valid the insert runs the bit-serial hash remainder,
// then the step remainder, then a read and a check state per slot examined
// on the registered-read slot table, then a state that writes the slot and
// loads the result register; when probing returns home it evicts and goes
// straight to that write. a new insert can be accepted the cycle after the
// result is loaded.
// after reset the busy map is cleared by a pass over all TABLE_DEPTH slots, during
// which insert_ch is not ready; table size returns to TABLE_DEPTH.
// the result register holds while result_ch is stalled; the next insert is
// still accepted and runs until its own result needs the register.
module hash_table_insert_digit_probe #(
    parameter int TABLE_DEPTH = htp_pkg::TABLE_DEPTH_DEF,
    parameter int HANDLE_BITS = htp_pkg::HANDLE_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [htp_pkg::CFG_W-1:0] cfg_data,
    htp_in_if.sink                    insert_ch,
    htp_out_if.source                 result_ch
);

    htp_pkg::htp_cmd_t cmd;
    htp_pkg::htp_sts_t sts;

    htp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    htp_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .insert_ch (insert_ch),
        .result_ch (result_ch)
    );

endmodule

@@ tb/hash_table_insert_digit_probe_test.sv @@
// self-checking testbench of the hash insert block with linear digit probe
module hash_table_insert_digit_probe_test;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_PER_SIZE = 67;

    typedef struct packed {
        logic [htp_pkg::DIGIT_W-1:0]  step_digit;
        logic [htp_pkg::DIGIT_W-1:0]  hundreds_digit;
        logic [htp_pkg::DIGIT_W-1:0]  tens_digit;
        logic [htp_pkg::DIGIT_W-1:0]  units_digit;
        logic [htp_pkg::HANDLE_W-1:0] entry_handle;
    } insert_word_t;

    typedef struct packed {
        logic [htp_pkg::SLOT_W-1:0]   slot_index;
        logic [htp_pkg::PROBE_W-1:0]  probe_count;
        logic [htp_pkg::TOTAL_W-1:0]  total_collisions;
        logic                         evicted;
        logic [htp_pkg::HANDLE_W-1:0] evicted_handle;
    } result_word_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [htp_pkg::CFG_W-1:0] cfg_data;

    htp_in_if  insert_ch ();
    htp_out_if result_ch ();

    hash_table_insert_digit_probe dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .insert_ch (insert_ch),
        .result_ch (result_ch)
    );

    // model of the table
    bit                           model_busy [htp_pkg::TABLE_DEPTH_DEF];
    logic [htp_pkg::HANDLE_W-1:0] model_handle [htp_pkg::TABLE_DEPTH_DEF];
    logic [htp_pkg::TOTAL_W-1:0]  model_total = '0;
    logic [htp_pkg::CFG_W-1:0]    model_size = htp_pkg::CFG_W'(htp_pkg::TABLE_DEPTH_DEF);

    insert_word_t pending_inserts [$];
    result_word_t expected_results [$];

    int inserts_queued = 0;
    int results_checked = 0;
    int evictions_seen = 0;
    int fail_count = 0;
    int send_idle_pct = 25;
    int recv_idle_pct = 86;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic result_word_t place_entry(insert_word_t w);
        result_word_t r;
        int size;
        int home;
        int idx;
        int probes;
        if (model_size == 0)
            size = 1;
        else if (model_size > htp_pkg::TABLE_DEPTH_DEF)
            size = htp_pkg::TABLE_DEPTH_DEF;
        else
            size = model_size;
        home = (w.hundreds_digit * htp_pkg::HUNDRED + w.tens_digit * htp_pkg::TEN
                + w.units_digit) % size;
        idx = home;
        probes = 0;
        r = '0;
        while (model_busy[idx])
        begin
            idx = (idx + w.step_digit) % size;
            probes++;
            if (model_total != '1)
                model_total++;
            if (idx == home)
            begin
                r.evicted = 1'b1;
                r.evicted_handle = model_handle[home];
                model_busy[home] = 1'b0;
            end
        end
        model_busy[idx] = 1'b1;
        model_handle[idx] = w.entry_handle;
        r.slot_index = idx[htp_pkg::SLOT_W-1:0];
        r.probe_count = probes[htp_pkg::PROBE_W-1:0];
        r.total_collisions = model_total;
        return r;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    task automatic queue_insert(int step, int d1, int d3, int d5, int handle);
        insert_word_t w;
        w.step_digit = htp_pkg::DIGIT_W'(step);
        w.hundreds_digit = htp_pkg::DIGIT_W'(d1);
        w.tens_digit = htp_pkg::DIGIT_W'(d3);
        w.units_digit = htp_pkg::DIGIT_W'(d5);
        w.entry_handle = htp_pkg::HANDLE_W'(handle);
        pending_inserts.push_back(w);
        inserts_queued++;
    endtask

    task automatic wait_drained();
        while (results_checked < inserts_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_table_size(int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= htp_pkg::CFG_W'(value);
        model_size = htp_pkg::CFG_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int random_digit();
        if ($urandom_range(9) == 0)
            return $urandom_range(15);
        return $urandom_range(9);
    endfunction

    // sender
    always @(posedge clk)
    begin
        insert_word_t w;
        if (!rst_n)
        begin
            insert_ch.valid <= 1'b0;
        end
        else
        begin
            if (insert_ch.valid && insert_ch.ready)
            begin
                w.step_digit = insert_ch.step_digit;
                w.hundreds_digit = insert_ch.hundreds_digit;
                w.tens_digit = insert_ch.tens_digit;
                w.units_digit = insert_ch.units_digit;
                w.entry_handle = insert_ch.entry_handle;
                expected_results.push_back(place_entry(w));
            end
            if (!insert_ch.valid || insert_ch.ready)
            begin
                if (pending_inserts.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    w = pending_inserts.pop_front();
                    insert_ch.step_digit <= w.step_digit;
                    insert_ch.hundreds_digit <= w.hundreds_digit;
                    insert_ch.tens_digit <= w.tens_digit;
                    insert_ch.units_digit <= w.units_digit;
                    insert_ch.entry_handle <= w.entry_handle;
                    insert_ch.valid <= 1'b1;
                end
                else
                begin
                    insert_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_checked++;
            if (result_ch.evicted === 1'b1)
                evictions_seen++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result word with none expected, slot %0d", $time,
                         result_ch.slot_index);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("slot_index", want.slot_index, result_ch.slot_index);
                check_field("probe_count", want.probe_count, result_ch.probe_count);
                check_field("total_collisions", want.total_collisions,
                            result_ch.total_collisions);
                check_field("evicted", want.evicted, result_ch.evicted);
                check_field("evicted_handle", want.evicted_handle, result_ch.evicted_handle);
            end
        end
    end

    // watchdog on cycles with no word moving
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((insert_ch.valid && insert_ch.ready) || (result_ch.valid && result_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int sizes [3][2];
        sizes = '{'{1024, 13}, '{2047, 1}, '{100, 0}};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        insert_ch.valid = 1'b0;
        insert_ch.step_digit = '0;
        insert_ch.hundreds_digit = '0;
        insert_ch.tens_digit = '0;
        insert_ch.units_digit = '0;
        insert_ch.entry_handle = '0;
        result_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed, full table size
        queue_insert(0, 0, 0, 0, 16'h0000);
        queue_insert(0, 0, 0, 0, 16'hFFFF);
        queue_insert(1, 0, 0, 0, 16'h1234);
        queue_insert(1, 0, 0, 0, 16'h5678);
        queue_insert(9, 9, 9, 9, 16'hFFFF);
        queue_insert(15, 15, 15, 15, 16'hA5A5);
        queue_insert(15, 15, 15, 15, 16'h5A5A);
        queue_insert(10, 12, 11, 14, 16'h8001);
        wait_drained();

        // single slot, then zero size acting as one
        write_table_size(1);
        queue_insert(0, 0, 0, 0, 16'h0001);
        queue_insert(9, 9, 9, 9, 16'h0002);
        queue_insert(15, 15, 15, 15, 16'h0003);
        wait_drained();
        write_table_size(0);
        queue_insert(5, 3, 2, 1, 16'h0004);
        queue_insert(0, 0, 0, 0, 16'h0005);
        wait_drained();

        // oversize acting as full depth, old slots still held
        write_table_size(2047);
        queue_insert(0, 9, 9, 9, 16'h0006);
        queue_insert(3, 9, 9, 9, 16'h0007);
        queue_insert(7, 15, 15, 15, 16'h0008);
        wait_drained();

        // step equal to size wraps straight home
        write_table_size(7);
        queue_insert(7, 0, 0, 0, 16'h0009);
        queue_insert(3, 0, 0, 0, 16'h000A);
        queue_insert(2, 0, 0, 1, 16'h000B);
        wait_drained();

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0: begin send_idle_pct = 25; recv_idle_pct = 86; end
                1: begin send_idle_pct = 86; recv_idle_pct = 25; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int s = 0; s < 2; s++)
            begin
                write_table_size(sizes[mode][s]);
                for (int n = 0; n < RANDOM_PER_SIZE; n++)
                    queue_insert(random_digit(), random_digit(), random_digit(),
                                 random_digit(), $urandom_range(16'hFFFF));
                if (mode == 2 && s == 0)
                begin
                    repeat (20) @(posedge clk);
                    hold_requests++;
                end
                wait_drained();
            end
        end

        repeat (100) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected result words never arrived", $time,
                     expected_results.size());
            fail_count++;
        end
        $display("%0d inserts checked over table sizes 0 to 2047 and three idling mixes",
                 results_checked);
        $display("%0d evictions seen, %0d collisions counted, %0d mismatches",
                 evictions_seen, model_total, fail_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/htp_pkg.sv
rtl/htp_in_if.sv
rtl/htp_out_if.sv
rtl/htp_ram.sv
rtl/htp_rem_unit.sv
rtl/htp_ctrl.sv
rtl/htp_datapath.sv
rtl/hash_table_insert_digit_probe.sv
tb/hash_table_insert_digit_probe_test.sv
